@@ rtl/bht_pkg.sv @@
// ----------------------------------------------------------------------------
// bht_pkg
// shared constants for the bucketed hash table: field widths, request and
// status codes, default geometry
// ----------------------------------------------------------------------------
package bht_pkg;

  localparam int NUM_BUCKETS_DEF      = 47;
  localparam int SLOTS_PER_BUCKET_DEF = 5;
  localparam int KEY_WIDTH_DEF        = 16;

  localparam int REQ_W    = 2;
  localparam int KEY_IN_W = 16;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 6;
  localparam int SLOT_W   = 3;

  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd3;

endpackage

@@ rtl/bht_if.sv @@
// ----------------------------------------------------------------------------
// bht_if
// valid/ready channels for requests and responses of the hash table
// ----------------------------------------------------------------------------
interface bht_req_if;
  logic                       valid;
  logic                       ready;
  logic [bht_pkg::REQ_W-1:0]    req_type;
  logic [bht_pkg::KEY_IN_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface bht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bht_pkg::STATUS_W-1:0] status;
  logic [bht_pkg::BUCKET_W-1:0] bucket;
  logic [bht_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output status, output bucket, output slot, input ready);
  modport sink (input valid, input status, input bucket, input slot, output ready);
endinterface

@@ rtl/bht_ram.sv @@
// ----------------------------------------------------------------------------
// bht_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bht_bucket.sv @@
// ----------------------------------------------------------------------------
// bht_bucket
// key modulo bucket count: reciprocal multiply registered, then one
// constant multiply, subtract and single correction step
// ----------------------------------------------------------------------------
module bht_bucket #(
  parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
  parameter int KEY_WIDTH   = bht_pkg::KEY_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           start,
  input  logic [KEY_WIDTH-1:0]           key,
  output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int SH = KEY_WIDTH + BW;
  localparam int MW = KEY_WIDTH + 1;
  localparam int PW = KEY_WIDTH + MW;
  localparam int RW = KEY_WIDTH + BW + 1;
  localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(NUM_BUCKETS);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] quot;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        prod_sh;
  logic [RW-1:0]        qn;
  logic [RW-1:0]        diff;
  logic [BW:0]          rem;
  logic [BW:0]          rem_fix;

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    quot <= prod_sh[KEY_WIDTH-1:0];
  end

  // quotient estimate, low by at most one
  assign prod    = PW'(key_r) * PW'(RECIP[MW-1:0]);
  assign prod_sh = prod >> SH;

  assign qn      = RW'(quot) * RW'(NUM_BUCKETS);
  assign diff    = RW'(key_r) - qn;
  assign rem     = diff[BW:0];
  assign rem_fix = (rem >= (BW+1)'(NUM_BUCKETS)) ? rem - (BW+1)'(NUM_BUCKETS) : rem;
  assign bucket  = rem_fix[BW-1:0];

endmodule

@@ rtl/bucket_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// bucket_hash_table_top
// hash table of buckets with a fixed number of slots; search, insert, delete
// a request passes S_MUL (modulo multiply), S_RD (bucket row read) and S_CMP
//   (compare and row write-back), where the response is registered once free
// a new request is taken in S_IDLE, or in S_CMP as the current one completes,
// so requests do not overlap; reset: a clearing pass writes every bucket row empty,
//   no request is taken until it ends
// ----------------------------------------------------------------------------
module bucket_hash_table_top #(
  parameter int NUM_BUCKETS      = bht_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int KEY_WIDTH        = bht_pkg::KEY_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bht_req_if.sink   req,
  bht_rsp_if.source rsp
);

  localparam int BW   = $clog2(NUM_BUCKETS);
  localparam int SLW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int EW   = KEY_WIDTH + 1;
  localparam int ROWW = SLOTS_PER_BUCKET * EW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0]                      state;
  logic [BW-1:0]                   clr_cnt;
  logic [bht_pkg::REQ_W-1:0]       op_q;
  logic [KEY_WIDTH-1:0]            key_q;
  logic [BW-1:0]                   bucket_q;
  logic                            out_valid;
  logic [bht_pkg::STATUS_W-1:0]    status_q;
  logic [bht_pkg::BUCKET_W-1:0]    bucket_out_q;
  logic [bht_pkg::SLOT_W-1:0]      slot_q;

  logic [31:0]                     key_ext;
  logic [KEY_WIDTH-1:0]            key_in;
  logic [BW-1:0]                   bucket_c;
  logic                            out_free;
  logic                            accept;
  logic                            load;

  logic [SLOTS_PER_BUCKET-1:0][EW-1:0] row_rd;
  logic [SLOTS_PER_BUCKET-1:0][EW-1:0] row_new;
  logic [SLOTS_PER_BUCKET-1:0]         hit;
  logic [SLOTS_PER_BUCKET-1:0]         free;
  logic [SLW-1:0]                      hit_idx;
  logic [SLW-1:0]                      free_idx;
  logic                                row_mod;
  logic [bht_pkg::STATUS_W-1:0]        status_c;
  logic [SLW-1:0]                      slot_c;
  logic [31:0]                         slot_ext;
  logic [31:0]                         bucket_ext;

  logic                            ram_we;
  logic [BW-1:0]                   ram_waddr;
  logic [ROWW-1:0]                 ram_wdata;
  logic [ROWW-1:0]                 ram_rdata;

  assign key_ext  = 32'(req.key);
  assign key_in   = key_ext[KEY_WIDTH-1:0];
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) || ((state == S_CMP) && out_free);
  assign accept   = req.valid && req.ready;
  assign load     = (state == S_CMP) && out_free;

  bht_bucket #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_bucket (
    .clk    (clk),
    .start  (accept),
    .key    (key_in),
    .bucket (bucket_c)
  );

  bht_ram #(
    .WIDTH (ROWW),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_RD),
    .raddr (bucket_c),
    .rdata (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // slot compare and priority pick
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      hit[s]  = row_rd[s][KEY_WIDTH] && (row_rd[s][KEY_WIDTH-1:0] == key_q);
      free[s] = !row_rd[s][KEY_WIDTH];
      if (hit[s]) begin
        hit_idx = SLW'(s);
      end
      if (free[s]) begin
        free_idx = SLW'(s);
      end
    end
  end

  always_comb begin
    row_new  = row_rd;
    row_mod  = 1'b0;
    status_c = bht_pkg::STATUS_NOT_FOUND;
    slot_c   = '0;
    case (op_q)
      bht_pkg::REQ_INSERT: begin
        if (|hit) begin
          status_c = bht_pkg::STATUS_DUPLICATE;
        end else if (|free) begin
          status_c          = bht_pkg::STATUS_OK;
          slot_c            = free_idx;
          row_new[free_idx] = {1'b1, key_q};
          row_mod           = 1'b1;
        end else begin
          status_c = bht_pkg::STATUS_OVERFLOW;
        end
      end
      bht_pkg::REQ_DELETE: begin
        if (|hit) begin
          status_c                    = bht_pkg::STATUS_OK;
          slot_c                      = hit_idx;
          row_new[hit_idx][KEY_WIDTH] = 1'b0;
          row_mod                     = 1'b1;
        end
      end
      default: begin
        if (|hit) begin
          status_c = bht_pkg::STATUS_OK;
          slot_c   = hit_idx;
        end
      end
    endcase
  end

  assign ram_we    = (state == S_CLR) || (load && row_mod);
  assign ram_waddr = (state == S_CLR) ? clr_cnt : bucket_q;
  assign ram_wdata = (state == S_CLR) ? '0 : ROWW'(row_new);

  assign slot_ext   = 32'(slot_c);
  assign bucket_ext = 32'(bucket_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BW'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (out_free) begin
            state <= accept ? S_MUL : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.req_type;
      key_q <= key_in;
    end
    if (state == S_RD) begin
      bucket_q <= bucket_c;
    end
    if (load) begin
      status_q     <= status_c;
      bucket_out_q <= bucket_ext[bht_pkg::BUCKET_W-1:0];
      slot_q       <= slot_ext[bht_pkg::SLOT_W-1:0];
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = status_q;
  assign rsp.bucket = bucket_out_q;
  assign rsp.slot   = slot_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bucketed hash table: directed search, insert
// and delete cases (empty table, key extremes, duplicates, full buckets,
// holes after deletes, the unused request code), then bursts of random
// traffic aimed at one or two hot buckets with random idling on both channels;
// every response transaction is checked against a local table model
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [bht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_KEY_MULT = 65535 / bht_pkg::NUM_BUCKETS_DEF;

  typedef struct packed {
    logic [bht_pkg::STATUS_W-1:0] status;
    logic [bht_pkg::BUCKET_W-1:0] bucket;
    logic [bht_pkg::SLOT_W-1:0]   slot;
  } lookup_rsp_t;

  logic clk;
  logic rst;

  bht_req_if req_ch ();
  bht_rsp_if rsp_ch ();

  bucket_hash_table_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [bht_pkg::KEY_IN_W-1:0] table_keys [bht_pkg::NUM_BUCKETS_DEF]
                                           [bht_pkg::SLOTS_PER_BUCKET_DEF];
  logic                         table_used [bht_pkg::NUM_BUCKETS_DEF]
                                           [bht_pkg::SLOTS_PER_BUCKET_DEF];
  lookup_rsp_t                  pending_rsp [$];
  int                           err_cnt;
  bit                           idle_en;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic lookup_rsp_t apply_request(input logic [bht_pkg::REQ_W-1:0] op,
                                                input logic [bht_pkg::KEY_IN_W-1:0] k);
    int          b;
    int          hit;
    lookup_rsp_t r;
    b   = k % bht_pkg::NUM_BUCKETS_DEF;
    hit = -1;
    for (int s = 0; s < bht_pkg::SLOTS_PER_BUCKET_DEF; s++) begin
      if (hit < 0 && table_used[b][s] && table_keys[b][s] == k) hit = s;
    end
    r.status = bht_pkg::STATUS_NOT_FOUND;
    r.bucket = b[bht_pkg::BUCKET_W-1:0];
    r.slot   = '0;
    case (op)
      bht_pkg::REQ_INSERT: begin
        if (hit >= 0) begin
          r.status = bht_pkg::STATUS_DUPLICATE;
        end else begin
          r.status = bht_pkg::STATUS_OVERFLOW;
          for (int s = 0; s < bht_pkg::SLOTS_PER_BUCKET_DEF; s++) begin
            if (r.status == bht_pkg::STATUS_OVERFLOW && !table_used[b][s]) begin
              table_used[b][s] = 1'b1;
              table_keys[b][s] = k;
              r.status = bht_pkg::STATUS_OK;
              r.slot   = s[bht_pkg::SLOT_W-1:0];
            end
          end
        end
      end
      bht_pkg::REQ_DELETE: begin
        if (hit >= 0) begin
          table_used[b][hit] = 1'b0;
          r.status = bht_pkg::STATUS_OK;
          r.slot   = hit[bht_pkg::SLOT_W-1:0];
        end
      end
      default: begin
        if (hit >= 0) begin
          r.status = bht_pkg::STATUS_OK;
          r.slot   = hit[bht_pkg::SLOT_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input logic [bht_pkg::REQ_W-1:0] op,
                          input logic [bht_pkg::KEY_IN_W-1:0] k);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(apply_request(op, k));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_req(bht_pkg::REQ_SEARCH, 16'd0);
    send_req(bht_pkg::REQ_INSERT, 16'd0);
    send_req(bht_pkg::REQ_INSERT, 16'd0);
    send_req(bht_pkg::REQ_SEARCH, 16'd0);
    send_req(bht_pkg::REQ_INSERT, 16'hffff);
    send_req(bht_pkg::REQ_SEARCH, 16'hffff);
    send_req(REQ_UNUSED, 16'hffff);
    send_req(bht_pkg::REQ_DELETE, 16'hffff);
    send_req(bht_pkg::REQ_DELETE, 16'hffff);
    send_req(bht_pkg::REQ_SEARCH, 16'hffff);
  endtask

  task automatic test_bucket_fill();
    for (int i = 0; i <= bht_pkg::SLOTS_PER_BUCKET_DEF; i++) begin
      send_req(bht_pkg::REQ_INSERT, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * i));
    end
  endtask

  task automatic test_holes();
    send_req(bht_pkg::REQ_DELETE, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 2));
    send_req(bht_pkg::REQ_SEARCH, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 4));
    send_req(bht_pkg::REQ_INSERT, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 5));
    send_req(bht_pkg::REQ_INSERT, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 3));
    send_req(bht_pkg::REQ_DELETE, 16'd5);
    send_req(bht_pkg::REQ_DELETE, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 5));
    send_req(bht_pkg::REQ_SEARCH, 16'(5 + bht_pkg::NUM_BUCKETS_DEF * 5));
  endtask

  task automatic test_random_traffic(input int num_bursts);
    int                           hot_cnt;
    int                           hot_bkt [2];
    int                           sel;
    int                           j;
    logic [bht_pkg::KEY_IN_W-1:0] key_pool [8];
    logic [bht_pkg::KEY_IN_W-1:0] k;
    logic [bht_pkg::REQ_W-1:0]    op;
    for (int burst = 0; burst < num_bursts; burst++) begin
      idle_en    = ($urandom_range(0, 3) != 0);
      hot_cnt    = $urandom_range(1, 2);
      hot_bkt[0] = $urandom_range(0, bht_pkg::NUM_BUCKETS_DEF - 1);
      hot_bkt[1] = $urandom_range(0, bht_pkg::NUM_BUCKETS_DEF - 1);
      for (int p = 0; p < 8; p++) begin
        j = $urandom_range(0, MAX_KEY_MULT);
        k = 16'(hot_bkt[p % hot_cnt] + bht_pkg::NUM_BUCKETS_DEF * j);
        if (hot_bkt[p % hot_cnt] + bht_pkg::NUM_BUCKETS_DEF * j > 65535)
          k = 16'(k - bht_pkg::NUM_BUCKETS_DEF);
        key_pool[p] = k;
      end
      for (int n = 0; n < 40; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          op = 2'($urandom_range(0, 3));
          k  = 16'($urandom_range(0, 65535));
        end else begin
          k = key_pool[$urandom_range(0, 7)];
          if (sel < 50) op = bht_pkg::REQ_INSERT;
          else if (sel < 75) op = bht_pkg::REQ_SEARCH;
          else if (sel < 96) op = bht_pkg::REQ_DELETE;
          else op = REQ_UNUSED;
        end
        send_req(op, k);
      end
      if (burst % 8 == 7) wait_drained();
    end
  endtask

  // response side: random stall, then check against the oldest expectation
  initial begin
    int          stall;
    lookup_rsp_t exp_rsp;
    lookup_rsp_t got_rsp;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = idle_en ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got_rsp.status = rsp_ch.status;
      got_rsp.bucket = rsp_ch.bucket;
      got_rsp.slot   = rsp_ch.slot;
      if (pending_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("response transaction with none expected: status %0d bucket %0d slot %0d",
                   got_rsp.status, got_rsp.bucket, got_rsp.slot);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (got_rsp.status !== exp_rsp.status || got_rsp.bucket !== exp_rsp.bucket ||
            got_rsp.slot !== exp_rsp.slot) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected status %0d bucket %0d slot %0d, got %0d %0d %0d",
                     exp_rsp.status, exp_rsp.bucket, exp_rsp.slot,
                     got_rsp.status, got_rsp.bucket, got_rsp.slot);
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    err_cnt         = 0;
    idle_en         = 1'b1;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = bht_pkg::REQ_SEARCH;
    req_ch.key      = '0;
    for (int b = 0; b < bht_pkg::NUM_BUCKETS_DEF; b++) begin
      for (int s = 0; s < bht_pkg::SLOTS_PER_BUCKET_DEF; s++) begin
        table_used[b][s] = 1'b0;
        table_keys[b][s] = '0;
      end
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    wait_drained();
    test_bucket_fill();
    idle_en = 1'b0;
    test_holes();
    wait_drained();
    test_random_traffic(30);
    wait_drained();
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
